// ===== hdl/fir_filter_q15_assert.svh =====
// Assertion macros used by the checker of the FIR filter.
`ifndef FIR_FILTER_Q15_ASSERT_SVH
`define FIR_FILTER_Q15_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fir_q15_pkg.sv =====
// ----------------------------------------------------------------------------
// FIR Q15 package
// Shared widths, codes and types of the digit-serial FIR filter.
// ----------------------------------------------------------------------------
package fir_q15_pkg;

  localparam int NUM_TAPS_DEF = 32;
  localparam int DATA_W       = 16;
  localparam int OP_W         = 2;
  localparam int IDX_W        = 5;
  localparam int TAPCNT_W     = 6;
  localparam int ACC_W        = 32;
  localparam int Q_SHIFT      = 15;
  localparam int CMP_W        = 9;
  localparam int DIGIT_W      = 4;
  localparam int NUM_DIGITS   = DATA_W / DIGIT_W;
  localparam int DCW          = $clog2(NUM_DIGITS);

  localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = TAPCNT_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PUSH    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic           clear;
    logic           load;
    logic           step;
    logic [DCW-1:0] digit;
  } mac_ctl_t;

endpackage

// ===== hdl/fir_q15_store.sv =====
// ----------------------------------------------------------------------------
// FIR Q15 tap store
// Coefficient memory and circular sample memory, registered reads.
// ----------------------------------------------------------------------------
module fir_q15_store import fir_q15_pkg::*; #(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              coef_we_i,
  input  logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] coef_waddr_i,
  input  logic                              samp_we_i,
  input  logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] samp_waddr_i,
  input  logic [DATA_W-1:0]                 wdata_i,
  input  logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] coef_raddr_i,
  input  logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] samp_raddr_i,
  output logic [DATA_W-1:0]                 coef_rdata_o,
  output logic [DATA_W-1:0]                 samp_rdata_o
);

  logic [DATA_W-1:0] coef_mem [NUM_TAPS];
  logic [DATA_W-1:0] samp_mem [NUM_TAPS];

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_mem[coef_waddr_i] <= wdata_i;
    end
    coef_rdata_o <= coef_mem[coef_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (samp_we_i) begin
      samp_mem[samp_waddr_i] <= wdata_i;
    end
    samp_rdata_o <= samp_mem[samp_raddr_i];
  end

endmodule

// ===== hdl/fir_q15_mac.sv =====
// ----------------------------------------------------------------------------
// FIR Q15 digit-serial MAC
// Multiplies one coefficient by one sample a 4-bit digit per cycle.
// ----------------------------------------------------------------------------
module fir_q15_mac import fir_q15_pkg::*; (
  input  logic              clk_i,
  input  mac_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] coef_i,
  input  logic [DATA_W-1:0] samp_i,
  output logic [ACC_W-1:0]  acc_o
);

  logic signed [DATA_W-1:0]         coef_q;
  logic [DATA_W-1:0]                samp_sr_q;
  logic [ACC_W-1:0]                 acc_q, acc_d;
  logic signed [DIGIT_W:0]          digit_s;
  logic signed [DATA_W+DIGIT_W:0]   prod;
  logic [ACC_W-1:0]                 prod_ext;
  logic [4:0]                       shamt;

  // Only the most significant digit of the sample carries the sign.
  always_comb begin
    if (ctl_i.digit == DCW'(NUM_DIGITS - 1)) begin
      digit_s = {samp_sr_q[DIGIT_W-1], samp_sr_q[DIGIT_W-1:0]};
    end else begin
      digit_s = {1'b0, samp_sr_q[DIGIT_W-1:0]};
    end
    prod     = coef_q * digit_s;
    prod_ext = ACC_W'(prod);
    shamt    = 5'(32'(ctl_i.digit) * DIGIT_W);
    acc_d    = acc_q + (prod_ext << shamt);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.step) begin
      acc_q <= acc_d;
    end
    if (ctl_i.load) begin
      coef_q    <= coef_i;
      samp_sr_q <= samp_i;
    end else if (ctl_i.step) begin
      samp_sr_q <= samp_sr_q >> DIGIT_W;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/fir_q15_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIR Q15 controller
// Decodes items, keeps fill count and pointers, sequences the taps.
// ----------------------------------------------------------------------------
module fir_q15_ctrl import fir_q15_pkg::*; #(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [TAPCNT_W-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            operation_i,
  input  logic [IDX_W-1:0]           coeff_index_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DATA_W-1:0]   filtered_o,
  input  logic [ACC_W-1:0]           acc_i,
  output mac_ctl_t                   mac_o,
  output logic                       coef_we_o,
  output logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] coef_waddr_o,
  output logic                       samp_we_o,
  output logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] samp_waddr_o,
  output logic [DATA_W-1:0]          wdata_o,
  output logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] coef_raddr_o,
  output logic [(NUM_TAPS>1 ? $clog2(NUM_TAPS) : 1)-1:0] samp_raddr_o
);

  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int CW = $clog2(NUM_TAPS + 1);

  state_e              state_q, state_d;
  logic [TAPCNT_W-1:0] tap_q;
  logic [CW-1:0]       fill_q, fill_next, act_t, left_q;
  logic [AW-1:0]       wr_ptr_q, cidx_q, sidx_q, start_idx;
  logic [AW-1:0]       wr_ptr_inc, cidx_inc, sidx_inc;
  logic                last_q;
  logic [DCW-1:0]      digit_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   filtered_q;
  logic [CMP_W-1:0]    tap_ext;
  logic [AW:0]         ptr_ext, off_ext;
  logic                accept, is_push, is_restart, start_fire, out_load;

  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = accept && (operation_i == OP_PUSH);
  assign is_restart = accept && (operation_i == OP_RESTART);

  // A tap count of zero acts as one, and one above the built size saturates.
  always_comb begin
    tap_ext = CMP_W'(tap_q);
    if (tap_q == '0) begin
      act_t = CW'(1);
    end else if (tap_ext > CMP_W'(NUM_TAPS)) begin
      act_t = CW'(NUM_TAPS);
    end else begin
      act_t = CW'(tap_ext);
    end
  end

  assign fill_next  = (fill_q == CW'(NUM_TAPS)) ? fill_q : fill_q + 1'b1;
  assign start_fire = is_push && (fill_next >= act_t);

  // The oldest sample in the window sits act_t - 1 slots behind the newest.
  always_comb begin
    ptr_ext = (AW+1)'(wr_ptr_q);
    off_ext = (AW+1)'(act_t - 1'b1);
    if (ptr_ext >= off_ext) begin
      start_idx = AW'(ptr_ext - off_ext);
    end else begin
      start_idx = AW'(ptr_ext + (AW+1)'(NUM_TAPS) - off_ext);
    end
  end

  assign wr_ptr_inc = (wr_ptr_q == AW'(NUM_TAPS - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign cidx_inc   = (cidx_q == AW'(NUM_TAPS - 1)) ? '0 : cidx_q + 1'b1;
  assign sidx_inc   = (sidx_q == AW'(NUM_TAPS - 1)) ? '0 : sidx_q + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_fire) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (digit_q == DCW'(NUM_DIGITS - 1)) begin
          state_d = last_q ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mac_o       = '0;
    out_load    = 1'b0;
    mac_o.digit = digit_q;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: mac_o.clear = 1'b1;
      ST_LOAD: mac_o.load = 1'b1;
      ST_MUL:  mac_o.step = 1'b1;
      ST_FIN:  out_load = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= TAPCNT_RESET;
      fill_q      <= '0;
      wr_ptr_q    <= '0;
      cidx_q      <= '0;
      sidx_q      <= '0;
      left_q      <= '0;
      last_q      <= 1'b0;
      digit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tap_q <= cfg_wdata_i;
      end
      if (is_restart) begin
        fill_q <= '0;
      end else if (is_push) begin
        fill_q   <= fill_next;
      end
      if (is_push) begin
        wr_ptr_q <= wr_ptr_inc;
      end
      if (start_fire) begin
        cidx_q <= '0;
        sidx_q <= start_idx;
        left_q <= act_t - 1'b1;
      end else if (state_q == ST_LOAD) begin
        cidx_q <= cidx_inc;
        sidx_q <= sidx_inc;
        left_q <= left_q - 1'b1;
        last_q <= (left_q == '0);
      end
      if (state_q == ST_LOAD) begin
        digit_q <= '0;
      end else if (state_q == ST_MUL) begin
        digit_q <= digit_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= acc_i[Q_SHIFT+DATA_W-1:Q_SHIFT];
    end
  end

  assign coef_we_o    = accept && (operation_i == OP_LOAD) &&
                        (CMP_W'(coeff_index_i) < CMP_W'(NUM_TAPS));
  assign coef_waddr_o = AW'(coeff_index_i);
  assign samp_we_o    = is_push;
  assign samp_waddr_o = wr_ptr_q;
  assign wdata_o      = value_i;
  assign coef_raddr_o = cidx_q;
  assign samp_raddr_o = sidx_q;
  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;

endmodule

// ===== hdl/fir_filter_q15.sv =====
// ----------------------------------------------------------------------------
// FIR filter, Q15
// Streaming direct-form FIR filter with a digit-serial multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per transfer: load a coefficient into
//   slot coeff_index_i, push a sample, or restart the window. Loads and
//   restarts leave the filter idle and never produce a result.
//   Once tap_count samples have been pushed since the last restart, each push
//   yields one filtered_o transfer on the output channel.
//   A productive push walks T active taps through one shared 16 x 4 bit
//   multiplier, one sample digit per cycle: a read step clears the sum,
//   each tap is one operand load and four digit steps, a final step loads
//   the output register, and a new item is taken as soon as it is loaded.
//   If the receiver stalls, the result waits in the output register; the
//   next input item is still taken, and a further result waits in its last
//   step until the register is free. Reset empties the window, clears the
//   output valid flag and sets tap_count to 32. The coefficient memory is
//   not cleared and must be loaded before use. cfg_we_i writes tap_count
//   at once; the user must write it only while the filter is idle, as the
//   block itself does not enforce this.
// ----------------------------------------------------------------------------
module fir_filter_q15 import fir_q15_pkg::*; #(
  parameter int NUM_TAPS = NUM_TAPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [TAPCNT_W-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OP_W-1:0]           operation_i,
  input  logic [IDX_W-1:0]          coeff_index_i,
  input  logic signed [DATA_W-1:0]  value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DATA_W-1:0]  filtered_o
);

  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

  mac_ctl_t          mac_ctl;
  logic [ACC_W-1:0]  acc;
  logic              coef_we, samp_we;
  logic [AW-1:0]     coef_waddr, samp_waddr, coef_raddr, samp_raddr;
  logic [DATA_W-1:0] wdata, coef_rdata, samp_rdata;

  fir_q15_ctrl #(
    .NUM_TAPS(NUM_TAPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .coeff_index_i (coeff_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_o    (filtered_o),
    .acc_i         (acc),
    .mac_o         (mac_ctl),
    .coef_we_o     (coef_we),
    .coef_waddr_o  (coef_waddr),
    .samp_we_o     (samp_we),
    .samp_waddr_o  (samp_waddr),
    .wdata_o       (wdata),
    .coef_raddr_o  (coef_raddr),
    .samp_raddr_o  (samp_raddr)
  );

  fir_q15_store #(
    .NUM_TAPS(NUM_TAPS)
  ) u_store (
    .clk_i        (clk_i),
    .coef_we_i    (coef_we),
    .coef_waddr_i (coef_waddr),
    .samp_we_i    (samp_we),
    .samp_waddr_i (samp_waddr),
    .wdata_i      (wdata),
    .coef_raddr_i (coef_raddr),
    .samp_raddr_i (samp_raddr),
    .coef_rdata_o (coef_rdata),
    .samp_rdata_o (samp_rdata)
  );

  fir_q15_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .coef_i (coef_rdata),
    .samp_i (samp_rdata),
    .acc_o  (acc)
  );

endmodule

// ===== hdl/fir_q15_checker.sv =====
// ----------------------------------------------------------------------------
// FIR Q15 port checker
// Temporal checks on the ports of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_filter_q15_assert.svh"

module fir_q15_checker import fir_q15_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [OP_W-1:0]           operation_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DATA_W-1:0]  filtered_o
);

  // A stalled result must stay on the output.
  `FQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `FQ_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(filtered_o), "stalled result changed")

  // Loads, restarts and unused codes never take the filter out of idle.
  `FQ_ASSERT_NEXT(a_nonpush_ready, in_valid_i && in_ready_o && operation_i != OP_PUSH, in_ready_o, "non-push transfer blocked input")

  // A result needs multiply-accumulate work after any transfer and never rises right after one.
  `FQ_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o, !$rose(out_valid_o), "result rose right after an input transfer")

endmodule

bind fir_filter_q15 fir_q15_checker u_fir_q15_checker (.*);
